### rtl/bpa_pkg.sv
// Package for the buddy page allocator: request/result types, widths, sequencer states.
`default_nettype none
package bpa_pkg;

  localparam int TREE_PAGES_DEF = 16384;
  localparam int CNT_W = 15;
  localparam int OFF_W = 14;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CNT_W-1:0] page_count;
    logic [OFF_W-1:0] page_offset;
  } bpa_req_t;

  typedef struct packed {
    logic             status;
    logic [OFF_W-1:0] block_offset;
    logic [CNT_W-1:0] avail_pages;
  } bpa_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_IROOT,
    S_ITEST,
    S_IL,
    S_IR,
    S_AROOT,
    S_AWAIT,
    S_ATEST,
    S_ASPL,
    S_ASPR,
    S_ARDL,
    S_ARDR,
    S_ACHO,
    S_AFIN,
    S_FWR,
    S_UCHK,
    S_UWR,
    S_DONE
  } bpa_state_t;

endpackage : bpa_pkg
`default_nettype wire

### rtl/bpa_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
`default_nettype none
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : bpa_ram
`default_nettype wire

### rtl/buddy_page_allocator_top.sv
// Buddy page allocator top level: request sequencer around the node-word RAM.
// Sequence: init clears the live part of the tree, then writes the node values
//   down the tree level by level; alloc walks down the tree and then back up,
//   updating parents; free writes the block node and walks up merging buddies.
// Throughput: one request at a time; busy stays high until the result strobe.
// Reset: rst clears the sequencer, free count and span; the RAM is not cleared,
//   it is unused until the first init, which clears the live part of the tree.
`default_nettype none
module buddy_page_allocator_top
  import bpa_pkg::*;
#(
  parameter int TREE_PAGES = TREE_PAGES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire bpa_req_t request,
  output logic          done,
  output bpa_rsp_t      result
);

  localparam int NW = $clog2(TREE_PAGES) + 1;   // node value width
  localparam int AW = $clog2(2 * TREE_PAGES);   // node index width
  localparam int LW = (NW > 16) ? NW : 16;      // rounded request width
  localparam int DEPTH = 2 * TREE_PAGES;

  // Smallest i with 2**i >= v.
  function automatic logic [5:0] ceil_log2(input logic [31:0] v);
    logic [5:0] r;
    r = 6'd0;
    for (int i = 31; i >= 0; i--) begin
      if ((33'(1) << i) >= {1'b0, v}) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

  bpa_state_t state, state_next;

  logic [NW-1:0]    span;
  logic [CNT_W-1:0] free_cnt;
  logic [AW-1:0]    blk;
  logic [NW-1:0]    cur;      // value of blk; remainder during init
  logic [NW-1:0]    bspan;    // span of blk; child span during init and walk up
  logic [NW-1:0]    start_off;
  logic [LW-1:0]    len;
  logic [NW-1:0]    vl;
  logic             merge;
  logic             fail;
  logic [OFF_W-1:0] res_off;
  logic [AW:0]      clr;

  // RAM port
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [NW-1:0] wdata, rdata;

  bpa_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Request decode
  logic [31:0]   u_sat;
  logic [5:0]    u_lg, r_lg;
  logic [NW-1:0] span_new;
  logic [LW-1:0] len_new;
  logic          free_bad;
  logic [AW-1:0] free_blk;

  assign u_sat = (32'(request.page_count) > 32'(TREE_PAGES)) ? 32'(TREE_PAGES)
                                                            : 32'(request.page_count);
  assign u_lg = ceil_log2(u_sat);
  assign r_lg = ceil_log2((request.page_count == '0) ? 32'd1 : 32'(request.page_count));
  assign span_new = NW'(1) << u_lg;
  assign len_new  = LW'(1) << r_lg;
  assign free_bad = (32'(len_new) > 32'(span)) || (32'(request.page_offset) >= 32'(span));
  assign free_blk = AW'((32'(span) >> r_lg) + (32'(request.page_offset) >> r_lg));

  // Datapath conditions
  logic [AW-1:0] lchild, rchild;
  logic          a_cond, a_big, i_go, clr_last;
  logic          c_l1, c_r1, c_l2, c_r2;
  logic [NW-1:0] sib, pval, i_left, i_right;

  assign lchild  = {blk[AW-2:0], 1'b0};
  assign rchild  = {blk[AW-2:0], 1'b1};
  assign a_cond  = (len <= LW'(cur)) && (len < LW'(bspan));
  assign a_big   = len > LW'(cur);
  assign i_go    = (cur != '0) && (cur < bspan);
  assign clr_last = clr == (((AW+1)'(span) << 1) - (AW+1)'(1));
  assign c_l1 = |(len & LW'(vl));
  assign c_r1 = |(len & LW'(rdata));
  assign c_l2 = len <= LW'(vl);
  assign c_r2 = len <= LW'(rdata);
  assign sib  = rdata;
  assign pval = (merge && cur == bspan && sib == bspan) ? NW'(bspan << 1) : (cur | sib);
  assign i_left  = (cur > bspan) ? bspan : cur;
  assign i_right = (cur > bspan) ? NW'(cur - bspan) : '0;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (request.mode)
            MODE_INIT:  state_next = S_CLR;
            MODE_ALLOC: state_next = (span == '0) ? S_DONE : S_AROOT;
            MODE_FREE:  state_next = free_bad ? S_DONE : S_FWR;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_CLR:   state_next = clr_last ? S_IROOT : S_CLR;
      S_IROOT: state_next = S_ITEST;
      S_ITEST: state_next = i_go ? S_IL : S_DONE;
      S_IL:    state_next = S_IR;
      S_IR:    state_next = S_ITEST;
      S_AROOT: state_next = S_AWAIT;
      S_AWAIT: state_next = S_ATEST;
      S_ATEST: begin
        if (a_cond) begin
          state_next = (cur == bspan) ? S_ASPL : S_ARDL;
        end else begin
          state_next = a_big ? S_DONE : S_AFIN;
        end
      end
      S_ASPL:  state_next = S_ASPR;
      S_ASPR:  state_next = S_ATEST;
      S_ARDL:  state_next = S_ARDR;
      S_ARDR:  state_next = S_ACHO;
      S_ACHO:  state_next = (c_l1 || c_r1 || c_l2 || c_r2) ? S_ATEST : S_DONE;
      S_AFIN:  state_next = S_UCHK;
      S_FWR:   state_next = S_UCHK;
      S_UCHK:  state_next = (blk == AW'(1)) ? S_DONE : S_UWR;
      S_UWR:   state_next = S_UCHK;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // RAM control
  always_comb begin
    we    = 1'b0;
    waddr = blk;
    wdata = '0;
    re    = 1'b0;
    raddr = blk;
    unique case (state)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr[AW-1:0];
      end
      S_IROOT: begin
        we    = 1'b1;
        wdata = cur;
      end
      S_IL: begin
        we    = 1'b1;
        waddr = lchild;
        wdata = i_left;
      end
      S_IR: begin
        we    = 1'b1;
        waddr = rchild;
        wdata = i_right;
      end
      S_AROOT: re = 1'b1;
      S_ASPL: begin
        we    = 1'b1;
        waddr = lchild;
        wdata = cur >> 1;
      end
      S_ASPR: begin
        we    = 1'b1;
        waddr = rchild;
        wdata = cur >> 1;
      end
      S_ARDL: begin
        re    = 1'b1;
        raddr = lchild;
      end
      S_ARDR: begin
        re    = 1'b1;
        raddr = rchild;
      end
      S_AFIN: we = 1'b1;
      S_FWR: begin
        we    = 1'b1;
        wdata = NW'(len);
      end
      S_UCHK: begin
        re    = blk != AW'(1);
        raddr = {blk[AW-1:1], ~blk[0]};
      end
      S_UWR: begin
        we    = 1'b1;
        waddr = blk >> 1;
        wdata = pval;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      span     <= '0;
      free_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start) begin
        if (request.mode == MODE_INIT) begin
          span     <= span_new;
          free_cnt <= CNT_W'(u_sat);
        end
      end
      if (state == S_AFIN) free_cnt <= free_cnt - CNT_W'(len);
      if (state == S_FWR)  free_cnt <= free_cnt + CNT_W'(len);
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        fail    <= 1'b0;
        res_off <= '0;
        clr     <= '0;
        blk     <= AW'(1);
        start_off <= '0;
        bspan   <= span;
        len     <= len_new;
        merge   <= 1'b0;
        if (request.mode == MODE_INIT) begin
          cur   <= NW'(u_sat);
          bspan <= span_new;
        end else if (request.mode == MODE_ALLOC) begin
          fail <= span == '0;
        end else begin
          blk   <= free_blk;
          cur   <= NW'(len_new);
          bspan <= NW'(len_new);
          merge <= 1'b1;
        end
      end
      S_CLR: clr <= clr + (AW+1)'(1);
      S_ITEST: bspan <= bspan >> 1;
      S_IR: begin
        cur <= (cur > bspan) ? NW'(cur - bspan) : cur;
        blk <= (cur > bspan) ? rchild : lchild;
      end
      S_AWAIT: cur <= rdata;
      S_ATEST: begin
        if (!a_cond && a_big) fail <= 1'b1;
      end
      S_ASPR: begin
        blk   <= lchild;
        cur   <= cur >> 1;
        bspan <= bspan >> 1;
      end
      S_ARDR: vl <= rdata;
      S_ACHO: begin
        bspan <= bspan >> 1;
        if (c_l1) begin
          blk <= lchild;
          cur <= vl;
        end else if (c_r1) begin
          blk <= rchild;
          cur <= rdata;
          start_off <= start_off + (bspan >> 1);
        end else if (c_l2) begin
          blk <= lchild;
          cur <= vl;
        end else if (c_r2) begin
          blk <= rchild;
          cur <= rdata;
          start_off <= start_off + (bspan >> 1);
        end else begin
          fail <= 1'b1;
        end
      end
      S_AFIN: begin
        res_off <= OFF_W'(start_off);
        cur     <= '0;
      end
      S_UWR: begin
        blk   <= blk >> 1;
        cur   <= pval;
        bspan <= NW'(bspan << 1);
      end
      default: ;
    endcase
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;
  assign result.status       = fail;
  assign result.block_offset = fail ? '0 : res_off;
  assign result.avail_pages  = free_cnt;

  // Accepted request always leaves idle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request accepted but block not busy");

  // No state reads and writes the RAM in the same cycle.
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(we && re)) else $error("RAM read and write overlap");

  // A result is only strobed in the cycle before returning to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("result strobe not followed by idle");

  // A failed allocation reports offset zero.
  a_fail_off: assert property (@(posedge clk) disable iff (rst)
    done && result.status |-> result.block_offset == '0)
    else $error("failed allocation with nonzero offset");

endmodule : buddy_page_allocator_top
`default_nettype wire
